/* design/ckc_pkg.sv */
// ckc_pkg: shared types and constants of the keep-out circle check
// used by circle_keepout_check_unit and ckc_sq_unit, no dependencies
package ckc_pkg;

  localparam int COORD_W   = 24;
  localparam int RAD_W     = 23;
  localparam int COUNT_W   = 5;
  localparam int DIM_W     = 2;
  localparam int SLOT_W    = 4;
  localparam int OPND_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * OPND_W;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int CKC_MAX_CIRCLES = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(0);
  localparam logic [DIM_W-1:0]   DIM_RESET    = DIM_W'(2);
  localparam logic [RAD_W-1:0]   MARGIN_RESET = RAD_W'(410);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_DIM    = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;

  // which square the shared unit computes
  typedef enum logic [1:0] {
    KIND_LIM = 2'd0,
    KIND_X   = 2'd1,
    KIND_Y   = 2'd2,
    KIND_Z   = 2'd3
  } ckc_kind_t;

  typedef struct packed {
    logic      vld;
    ckc_kind_t kind;
  } ckc_tag_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [RAD_W-1:0]   rad;
  } ckc_entry_t;

endpackage

/* design/ckc_ram.sv */
// ckc_ram: generic single write port, single read port ram with registered read
// no dependencies
module ckc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/ckc_sq_unit.sv */
// ckc_sq_unit: shared two-stage squaring unit, operand select then multiply
// depends on ckc_pkg
module ckc_sq_unit
  import ckc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ckc_tag_t           issue,
  input  logic [COORD_W-1:0] px,
  input  logic [COORD_W-1:0] py,
  input  logic [COORD_W-1:0] pz,
  input  ckc_entry_t         entry,
  input  logic [RAD_W-1:0]   margin,
  output ckc_tag_t           prod_tag,
  output logic [PROD_W-1:0]  prod
);

  logic [OPND_W-1:0] opnd;
  logic [OPND_W-1:0] opnd_r;
  logic [PROD_W-1:0] prod_r;
  ckc_tag_t          tag1_r;
  ckc_tag_t          tag2_r;
  logic [COORD_W-1:0] pa;
  logic [COORD_W-1:0] ca;
  logic signed [OPND_W-1:0] d_pc;
  logic signed [OPND_W-1:0] d_cp;

  always_comb begin
    case (issue.kind)
      KIND_Y:  begin pa = py; ca = entry.cy; end
      KIND_Z:  begin pa = pz; ca = entry.cz; end
      default: begin pa = px; ca = entry.cx; end
    endcase
  end

  // both differences in parallel, keep the non-negative one
  assign d_pc = $signed({pa[COORD_W-1], pa}) - $signed({ca[COORD_W-1], ca});
  assign d_cp = $signed({ca[COORD_W-1], ca}) - $signed({pa[COORD_W-1], pa});

  always_comb begin
    if (issue.kind == KIND_LIM) begin
      opnd = {2'b00, entry.rad} + {2'b00, margin};
    end else if (d_pc[OPND_W-1]) begin
      opnd = d_cp;
    end else begin
      opnd = d_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= issue;
      tag2_r <= tag1_r;
    end
    opnd_r <= opnd;
    prod_r <= opnd_r * opnd_r;
  end

  assign prod_tag = tag2_r;
  assign prod     = prod_r;

endmodule

/* design/circle_keepout_check_unit.sv */
// circle_keepout_check_unit: keep-out circle table and point membership query
// depends on ckc_pkg, ckc_ram, ckc_sq_unit
//
// A load transfer (command 0) writes one table slot and gives no result. A
// query transfer (command 1) walks the first circle_count slots (at most
// MAX_CIRCLES) one circle at a time through a single shared squaring
// multiplier: each circle takes a table read, one square for the limit and
// one per coordinate (dimension zero counted as one), a multiplier drain,
// then sum and compare. The walk stops at the first hit. The input is held
// stalled until the result has moved into the output register, and an
// empty table answers without a walk. The result sits in an output register,
// so loads are taken while it waits. Table slots are undefined until loaded.
module circle_keepout_check_unit
  import ckc_pkg::*;
#(
  parameter int MAX_CIRCLES = CKC_MAX_CIRCLES
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [COORD_W-1:0] in_coord_x,
  input  logic [COORD_W-1:0] in_coord_y,
  input  logic [COORD_W-1:0] in_coord_z,
  input  logic [RAD_W-1:0]   in_radius,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_in_unsafe,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam int AW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ISSUE,
    S_WAIT,
    S_CMP,
    S_FIN
  } state_t;

  // configuration
  logic [COUNT_W-1:0] cfg_count_r;
  logic [DIM_W-1:0]   cfg_dim_r;
  logic [RAD_W-1:0]   cfg_margin_r;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r  <= COUNT_RESET;
      cfg_dim_r    <= DIM_RESET;
      cfg_margin_r <= MARGIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_COUNT:  cfg_count_r  <= cfg_pwdata[COUNT_W-1:0];
        REG_DIM:    cfg_dim_r    <= cfg_pwdata[DIM_W-1:0];
        REG_MARGIN: cfg_margin_r <= cfg_pwdata[RAD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_COUNT:  cfg_prdata = PDATA_W'(cfg_count_r);
      REG_DIM:    cfg_prdata = PDATA_W'(cfg_dim_r);
      REG_MARGIN: cfg_prdata = PDATA_W'(cfg_margin_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // sequencer state
  state_t             state_r, state_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [1:0]         last_r, last_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [COORD_W-1:0] px_r, px_nxt;
  logic [COORD_W-1:0] py_r, py_nxt;
  logic [COORD_W-1:0] pz_r, pz_nxt;
  logic [PROD_W-1:0]  acc_r, acc_nxt;
  logic [PROD_W-1:0]  lim2_r, lim2_nxt;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_unsafe_r, out_unsafe_nxt;

  logic               in_acc;
  logic               ram_we;
  ckc_entry_t         wr_entry;
  ckc_entry_t         rd_entry;
  ckc_tag_t           issue;
  ckc_tag_t           prod_tag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    dist2;
  logic               hit_now;
  logic               last_circle;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ram_we   = in_acc && (in_command == CMD_LOAD) && (int'(in_slot) < MAX_CIRCLES);

  assign wr_entry.cx  = in_coord_x;
  assign wr_entry.cy  = in_coord_y;
  assign wr_entry.cz  = in_coord_z;
  assign wr_entry.rad = in_radius;

  ckc_ram #(
    .WIDTH ($bits(ckc_entry_t)),
    .DEPTH (MAX_CIRCLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata (wr_entry),
    .raddr (idx_r),
    .rdata (rd_entry)
  );

  assign issue.vld  = (state_r == S_ISSUE);
  assign issue.kind = ckc_kind_t'(phase_r);

  ckc_sq_unit u_sq (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .px       (px_r),
    .py       (py_r),
    .pz       (pz_r),
    .entry    (rd_entry),
    .margin   (cfg_margin_r),
    .prod_tag (prod_tag),
    .prod     (prod)
  );

  assign dist2       = {1'b0, acc_r} + {1'b0, prod};
  assign hit_now     = (dist2 <= {1'b0, lim2_r});
  assign last_circle = ((CW'(idx_r) + CW'(1)) == n_r);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    last_nxt       = last_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    pz_nxt         = pz_r;
    acc_nxt        = acc_r;
    lim2_nxt       = lim2_r;
    hit_nxt        = hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_unsafe_nxt = out_unsafe_r;

    // fold finished squares: the limit first, then the coordinates
    if (prod_tag.vld) begin
      if (prod_tag.kind == KIND_LIM) begin
        lim2_nxt = prod;
      end else begin
        acc_nxt = acc_r + prod;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_QUERY)) begin
          px_nxt   = in_coord_x;
          py_nxt   = in_coord_y;
          pz_nxt   = in_coord_z;
          last_nxt = (cfg_dim_r == 2'd0) ? 2'd1 : cfg_dim_r;
          n_nxt    = (int'(cfg_count_r) > MAX_CIRCLES) ? CW'(MAX_CIRCLES) : CW'(cfg_count_r);
          idx_nxt  = '0;
          if (cfg_count_r == '0) begin
            hit_nxt   = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        acc_nxt   = '0;
        phase_nxt = 2'd0;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        phase_nxt = phase_r + 2'd1;
        if (phase_r == last_r) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit_now || last_circle) begin
          hit_nxt   = hit_now;
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_READ;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_unsafe_nxt = hit_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r      <= phase_nxt;
    last_r       <= last_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    pz_r         <= pz_nxt;
    acc_r        <= acc_nxt;
    lim2_r       <= lim2_nxt;
    hit_r        <= hit_nxt;
    out_unsafe_r <= out_unsafe_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_in_unsafe = out_unsafe_r;

  // the compare always sees the last coordinate square leaving the multiplier
  a_cmp_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (prod_tag.vld && (prod_tag.kind == ckc_kind_t'(last_r))))
    else $error("compare not aligned with last square");

  // the table walk never passes the active circle count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (CW'(idx_r) < n_r))
    else $error("table index beyond circle count");

  // a new result only comes out of the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && out_stall)) |-> $past(state_r == S_FIN))
    else $error("result without finished query");

  // the multiplier is idle whenever the block waits for input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r == S_IDLE)) |-> !prod_tag.vld)
    else $error("multiplier busy while idle");

endmodule
